// ===== sv/tts_pkg.sv =====
// Shared types, codes and defaults of the tick task scheduler table.
`timescale 1ns / 1ps

package tts_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int RESULT_CAP     = 8;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_ADD      = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_DEL  = 3'd2;
  localparam logic [2:0] KIND_RUN  = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd4;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } slot_entry_t;

  typedef struct packed {
    logic       emit;
    logic       close;
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] tag;
    logic       err;
  } res_event_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] tag;
    logic       err;
    logic       last;
  } result_t;

endpackage

// ===== sv/tts_in_if.sv =====
// Request channel of the tick task scheduler table.
`timescale 1ns / 1ps

interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  task_tag;
  logic [15:0] start_delay;
  logic [15:0] repeat_period;
  logic [7:0]  slot_number;

  modport source (
    output valid, opcode, task_tag, start_delay, repeat_period, slot_number,
    input  ready
  );
  modport sink (
    input  valid, opcode, task_tag, start_delay, repeat_period, slot_number,
    output ready
  );
endinterface

// ===== sv/tts_out_if.sv =====
// Result channel of the tick task scheduler table.
`timescale 1ns / 1ps

interface tts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [3:0] slot_out;
  logic [7:0] tag_out;
  logic       error_flag;
  logic       last_result;

  modport source (
    output valid, result_kind, slot_out, tag_out, error_flag, last_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, slot_out, tag_out, error_flag, last_result,
    output ready
  );
endinterface

// ===== sv/tts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tts_ram #(
  parameter int WIDTH = $bits(tts_pkg::slot_entry_t),
  parameter int DEPTH = tts_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tts_ctrl.sv =====
// Sequencer: for tick and dispatch, walks the slot table in memory with read-modify-write per slot.
`timescale 1ns / 1ps

module tts_ctrl #(
  parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  tts_in_if.sink                  in_req,
  input  logic                    stall,
  output tts_pkg::res_event_t     ev,
  output logic                    ram_we,
  output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] ram_waddr,
  output tts_pkg::slot_entry_t    ram_wdata,
  output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] ram_raddr,
  input  tts_pkg::slot_entry_t    ram_rdata
);

  localparam int IW    = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(tts_pkg::RESULT_CAP + 1);
  localparam logic [IW-1:0]    LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CAP      = CNT_W'(tts_pkg::RESULT_CAP);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_ADD    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [IW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]         s2_idx_r, s2_idx_nxt;
  logic                  rd_done_r, rd_done_nxt;
  logic                  s2_vld_r, s2_vld_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [1:0]            op_r, op_nxt;
  logic [7:0]            tag_r, tag_nxt;
  logic [15:0]           delay_r, delay_nxt;
  logic [15:0]           period_r, period_nxt;
  logic [3:0]            res_slot_r, res_slot_nxt;
  logic                  res_err_r, res_err_nxt;

  logic                  accept;
  logic                  slot_ok;
  tts_pkg::slot_entry_t  upd;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign slot_ok      = {1'b0, in_req.slot_number} < 9'(SLOT_COUNT);

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    rd_idx_nxt   = rd_idx_r;
    s2_idx_nxt   = s2_idx_r;
    rd_done_nxt  = rd_done_r;
    s2_vld_nxt   = s2_vld_r;
    cnt_nxt      = cnt_r;
    op_nxt       = op_r;
    tag_nxt      = tag_r;
    delay_nxt    = delay_r;
    period_nxt   = period_r;
    res_slot_nxt = res_slot_r;
    res_err_nxt  = res_err_r;
    ev           = '0;
    ram_we       = 1'b0;
    ram_waddr    = s2_idx_r;
    ram_raddr    = rd_idx_r;
    upd          = ram_rdata;
    ram_wdata    = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = in_req.opcode;
          tag_nxt      = in_req.task_tag;
          delay_nxt    = in_req.start_delay;
          period_nxt   = in_req.repeat_period;
          rd_idx_nxt   = '0;
          rd_done_nxt  = 1'b0;
          s2_vld_nxt   = 1'b0;
          cnt_nxt      = '0;
          res_slot_nxt = '0;
          res_err_nxt  = 1'b0;
          case (in_req.opcode)
            tts_pkg::OP_ADD: begin
              state_nxt = ST_ADD;
            end
            tts_pkg::OP_DELETE: begin
              if (slot_ok) begin
                valid_nxt[in_req.slot_number[IW-1:0]] = 1'b0;
                res_slot_nxt = 4'(in_req.slot_number);
              end else begin
                res_err_nxt = 1'b1;
              end
              state_nxt = ST_FINISH;
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (stall) begin
          ram_raddr = s2_idx_r;
        end else begin
          if (!rd_done_r) begin
            s2_vld_nxt  = 1'b1;
            s2_idx_nxt  = rd_idx_r;
            rd_done_nxt = (rd_idx_r == LAST_IDX);
            rd_idx_nxt  = rd_idx_r + 1'b1;
          end else begin
            s2_vld_nxt = 1'b0;
          end
          if (s2_vld_r) begin
            if (valid_r[s2_idx_r]) begin
              if (op_r == tts_pkg::OP_TICK) begin
                if (ram_rdata.delay == 16'd0) begin
                  if (ram_rdata.pending != 8'hFF) begin
                    upd.pending = ram_rdata.pending + 8'd1;
                  end
                  if (ram_rdata.period != 16'd0) begin
                    upd.delay = ram_rdata.period - 16'd1;
                  end
                end else begin
                  upd.delay = ram_rdata.delay - 16'd1;
                end
                ram_we = 1'b1;
              end else if (ram_rdata.pending != 8'd0 && cnt_r < CAP) begin
                ev.emit     = 1'b1;
                ev.kind     = tts_pkg::KIND_RUN;
                ev.slot     = 4'(s2_idx_r);
                ev.tag      = ram_rdata.tag;
                upd.pending = ram_rdata.pending - 8'd1;
                ram_we      = 1'b1;
                cnt_nxt     = cnt_r + 1'b1;
                if (ram_rdata.period == 16'd0) begin
                  valid_nxt[s2_idx_r] = 1'b0;
                end
              end
            end
            ram_wdata = upd;
            if (s2_idx_r == LAST_IDX) begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end

      ST_ADD: begin
        if (!stall) begin
          if (!valid_r[rd_idx_r]) begin
            ram_we              = 1'b1;
            ram_waddr           = rd_idx_r;
            ram_wdata           = '{tag: tag_r, delay: delay_r, period: period_r,
                                    pending: 8'd0};
            valid_nxt[rd_idx_r] = 1'b1;
            res_slot_nxt        = 4'(rd_idx_r);
            state_nxt           = ST_FINISH;
          end else if (rd_idx_r == LAST_IDX) begin
            res_slot_nxt = 4'(SLOT_COUNT);
            res_err_nxt  = 1'b1;
            state_nxt    = ST_FINISH;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
      end

      ST_FINISH: begin
        if (!stall) begin
          ev.close = 1'b1;
          ev.slot  = res_slot_r;
          ev.err   = res_err_r;
          case (op_r)
            tts_pkg::OP_TICK:   ev.kind = tts_pkg::KIND_TICK;
            tts_pkg::OP_ADD:    ev.kind = tts_pkg::KIND_ADD;
            tts_pkg::OP_DELETE: ev.kind = tts_pkg::KIND_DEL;
            default:            ev.kind = tts_pkg::KIND_RUN;
          endcase
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      rd_idx_r  <= '0;
      s2_idx_r  <= '0;
      rd_done_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      rd_idx_r  <= rd_idx_nxt;
      s2_idx_r  <= s2_idx_nxt;
      rd_done_r <= rd_done_nxt;
      s2_vld_r  <= s2_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    delay_r    <= delay_nxt;
    period_r   <= period_nxt;
    res_slot_r <= res_slot_nxt;
    res_err_r  <= res_err_nxt;
  end

endmodule

// ===== sv/tts_out.sv =====
// Result stage: holds the latest dispatched slot and drives the output register.
`timescale 1ns / 1ps

module tts_out (
  input  logic                clk,
  input  logic                rst_n,
  input  tts_pkg::res_event_t ev,
  output logic                stall,
  tts_out_if.source           out_res
);

  logic            hold_vld_r, hold_vld_nxt;
  logic [3:0]      hold_slot_r, hold_slot_nxt;
  logic [7:0]      hold_tag_r, hold_tag_nxt;
  logic            out_vld_r, out_vld_nxt;
  tts_pkg::result_t out_r, out_nxt;
  logic            push;
  tts_pkg::result_t push_res;

  assign stall = out_vld_r && !out_res.ready;

  always_comb begin
    push          = 1'b0;
    push_res      = '{kind: tts_pkg::KIND_RUN, slot: hold_slot_r, tag: hold_tag_r,
                      err: 1'b0, last: 1'b0};
    hold_vld_nxt  = hold_vld_r;
    hold_slot_nxt = hold_slot_r;
    hold_tag_nxt  = hold_tag_r;

    if (ev.emit) begin
      push          = hold_vld_r;
      hold_vld_nxt  = 1'b1;
      hold_slot_nxt = ev.slot;
      hold_tag_nxt  = ev.tag;
    end else if (ev.close) begin
      push = 1'b1;
      if (ev.kind == tts_pkg::KIND_RUN) begin
        hold_vld_nxt = 1'b0;
        if (hold_vld_r) begin
          push_res.last = 1'b1;
        end else begin
          push_res = '{kind: tts_pkg::KIND_NONE, slot: 4'd0, tag: 8'd0,
                       err: 1'b0, last: 1'b1};
        end
      end else begin
        push_res = '{kind: ev.kind, slot: ev.slot, tag: 8'd0, err: ev.err,
                     last: 1'b1};
      end
    end

    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (push) begin
      out_vld_nxt = 1'b1;
      out_nxt     = push_res;
    end else if (out_res.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_slot_r <= hold_slot_nxt;
    hold_tag_r  <= hold_tag_nxt;
    out_r       <= out_nxt;
  end

  assign out_res.valid       = out_vld_r;
  assign out_res.result_kind = out_r.kind;
  assign out_res.slot_out    = out_r.slot;
  assign out_res.tag_out     = out_r.tag;
  assign out_res.error_flag  = out_r.err;
  assign out_res.last_result = out_r.last;

endmodule

// ===== sv/tick_task_scheduler_table_unit.sv =====
// Top level of the tick task scheduler table.
//
// Requests arrive on in_req (valid/ready): tick, add, delete or dispatch.
// Results leave on out_res (valid/ready); every request yields one or more
// results and the final one carries last_result.
// Slot state (tag, delay, period, pending count) sits in one RAM with a
// registered read; valid marks sit in flip-flops.
// Tick and dispatch walk the table one slot per cycle while out_res does not
// stall, reading slot i+1 while slot i is written back.
// Add scans valid marks, one slot per cycle while out_res does not stall.
// A new request is taken once the previous one has handed its last result
// to the output register.
// Dispatch reports at most eight slots; its last result is sent from the
// finish state after the walk ends.
// Reset clears all valid marks and control state at once; no RAM sweep.
// While out_res is stalled the walk and the RAM read hold in place.
`timescale 1ns / 1ps

module tick_task_scheduler_table_unit #(
  parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tts_in_if.sink    in_req,
  tts_out_if.source out_res
);

  localparam int IW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

  tts_pkg::res_event_t  ev;
  logic                 stall;
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [IW-1:0]        ram_raddr;
  tts_pkg::slot_entry_t ram_wdata;
  tts_pkg::slot_entry_t ram_rdata;

  tts_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .stall     (stall),
    .ev        (ev),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tts_ram #(
    .WIDTH ($bits(tts_pkg::slot_entry_t)),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tts_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .ev      (ev),
    .stall   (stall),
    .out_res (out_res)
  );

endmodule

// ===== sv/tts_chk.sv =====
// Port-level assertions for the tick task scheduler table, with bind.
`timescale 1ns / 1ps

module tts_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] result_kind,
  input logic [3:0] slot_out,
  input logic [7:0] tag_out,
  input logic       error_flag,
  input logic       last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({result_kind, slot_out, tag_out,
                                         error_flag, last_result}))
    else $error("result changed while stalled");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_flag |->
      result_kind == tts_pkg::KIND_ADD || result_kind == tts_pkg::KIND_DEL)
    else $error("error flag on a result that cannot fail");

  a_tag_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind != tts_pkg::KIND_RUN |-> tag_out == 8'd0)
    else $error("tag on a result that is not a dispatched task");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind != tts_pkg::KIND_RUN |-> last_result)
    else $error("single result request not marked last");

endmodule

bind tick_task_scheduler_table_unit tts_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .result_kind (out_res.result_kind),
  .slot_out    (out_res.slot_out),
  .tag_out     (out_res.tag_out),
  .error_flag  (out_res.error_flag),
  .last_result (out_res.last_result)
);

// ===== tb/tb.sv =====
// Self-checking bench for the tick task scheduler table against a slot-table predictor.
`timescale 1ns / 1ps

module tb;

  localparam int SLOT_N       = tts_pkg::SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 145;
  localparam int QUIET_FROM   = 500;
  localparam int QUIET_TO     = 1300;
  localparam int STALL_AT     = 60;
  localparam int STALL_LEN    = 200;

  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  slot;
    bit          pause;
  } sched_req_t;

  logic clk;
  logic rst_n;

  tts_in_if  in_ch ();
  tts_out_if out_ch ();

  tick_task_scheduler_table_unit #(
    .SLOT_COUNT(SLOT_N)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_res(out_ch)
  );

  bit                   slot_live [SLOT_N];
  tts_pkg::slot_entry_t slot_tab  [SLOT_N];

  sched_req_t       req_backlog [$];
  tts_pkg::result_t owed_results [$];
  sched_req_t       on_bus;

  int  cyc;
  int  reqs_taken;
  int  results_owed;
  int  results_got;
  int  mismatches;
  int  hold_left;
  bit  held_once;
  wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  task automatic drop_slot(input int s);
    slot_live[s] = 1'b0;
    slot_tab[s]  = '0;
  endtask

  task automatic apply_request(input sched_req_t r, output int produced);
    int               s;
    int               pick;
    int               n;
    tts_pkg::result_t res;
    tts_pkg::result_t run_res;
    produced = 1;
    pick     = -1;
    n        = 0;
    res      = '0;
    run_res  = '0;
    res.last = 1'b1;
    case (r.opcode)
      tts_pkg::OP_TICK: begin
        for (s = 0; s < SLOT_N; s++) begin
          if (slot_live[s]) begin
            if (slot_tab[s].delay == 16'd0) begin
              if (slot_tab[s].pending != 8'hFF) slot_tab[s].pending = slot_tab[s].pending + 8'd1;
              if (slot_tab[s].period != 16'd0) slot_tab[s].delay = slot_tab[s].period - 16'd1;
            end else begin
              slot_tab[s].delay = slot_tab[s].delay - 16'd1;
            end
          end
        end
        res.kind = tts_pkg::KIND_TICK;
        owed_results.push_back(res);
      end
      tts_pkg::OP_ADD: begin
        for (s = 0; s < SLOT_N; s++) begin
          if (!slot_live[s] && pick < 0) pick = s;
        end
        res.kind = tts_pkg::KIND_ADD;
        if (pick < 0) begin
          res.slot = 4'(SLOT_N);
          res.err  = 1'b1;
        end else begin
          slot_live[pick]        = 1'b1;
          slot_tab[pick].tag     = r.tag;
          slot_tab[pick].delay   = r.delay;
          slot_tab[pick].period  = r.period;
          slot_tab[pick].pending = 8'd0;
          res.slot               = 4'(pick);
        end
        owed_results.push_back(res);
      end
      tts_pkg::OP_DELETE: begin
        res.kind = tts_pkg::KIND_DEL;
        if (r.slot >= SLOT_N) begin
          res.err = 1'b1;
        end else begin
          drop_slot(int'(r.slot));
          res.slot = r.slot[3:0];
        end
        owed_results.push_back(res);
      end
      default: begin
        for (s = 0; s < SLOT_N && n < tts_pkg::RESULT_CAP; s++) begin
          if (slot_live[s] && slot_tab[s].pending != 8'd0) begin
            if (n > 0) owed_results.push_back(run_res);
            run_res      = '0;
            run_res.kind = tts_pkg::KIND_RUN;
            run_res.slot = 4'(s);
            run_res.tag  = slot_tab[s].tag;
            n++;
            slot_tab[s].pending = slot_tab[s].pending - 8'd1;
            if (slot_tab[s].period == 16'd0) drop_slot(s);
          end
        end
        if (n == 0) begin
          res.kind = tts_pkg::KIND_NONE;
          owed_results.push_back(res);
        end else begin
          run_res.last = 1'b1;
          owed_results.push_back(run_res);
          produced = n;
        end
      end
    endcase
  endtask

  task automatic queue_req(input logic [1:0] op, input logic [7:0] tag,
                           input logic [15:0] delay, input logic [15:0] period,
                           input logic [7:0] slot);
    sched_req_t r;
    r.opcode = op;
    r.tag    = tag;
    r.delay  = delay;
    r.period = period;
    r.slot   = slot;
    r.pause  = 1'b0;
    req_backlog.push_back(r);
  endtask

  task automatic queue_pause();
    sched_req_t r;
    r       = '{default: '0};
    r.pause = 1'b1;
    req_backlog.push_back(r);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  always @(posedge clk) begin : drive
    sched_req_t nxt;
    int         produced;
    logic       go;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(on_bus, produced);
        reqs_taken   <= reqs_taken + 1;
        results_owed <= results_owed + produced;
      end
      if (!in_ch.valid || in_ch.ready) begin
        go = 1'b0;
        if (req_backlog.size() > 0 && req_backlog[0].pause) begin
          // hold until every owed result has come back
          if (!in_ch.valid && results_owed == results_got) void'(req_backlog.pop_front());
        end else if (req_backlog.size() > 0 && (quiet || $urandom_range(0, 99) >= 13)) begin
          nxt                 = req_backlog.pop_front();
          go                  = 1'b1;
          on_bus              <= nxt;
          in_ch.opcode        <= nxt.opcode;
          in_ch.task_tag      <= nxt.tag;
          in_ch.start_delay   <= nxt.delay;
          in_ch.repeat_period <= nxt.period;
          in_ch.slot_number   <= nxt.slot;
        end
        in_ch.valid <= go;
      end
    end
  end

  always @(posedge clk) begin : observe
    tts_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("result with none owed: kind %0d, slot %0d, tag %0d",
                 out_ch.result_kind, out_ch.slot_out, out_ch.tag_out);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          results_got <= results_got + 1;
          check_field("result_kind", want.kind, out_ch.result_kind);
          check_field("slot_out", want.slot, out_ch.slot_out);
          check_field("tag_out", want.tag, out_ch.tag_out);
          check_field("error_flag", want.err, out_ch.error_flag);
          check_field("last_result", want.last, out_ch.last_result);
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!held_once && reqs_taken >= STALL_AT) begin
        held_once    <= 1'b1;
        hold_left    <= STALL_LEN;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  initial begin : stimulus
    int          s;
    int          rnd_count;
    int          k;
    logic [15:0] dly;
    logic [15:0] per;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = tts_pkg::OP_TICK;
    in_ch.task_tag      = '0;
    in_ch.start_delay   = '0;
    in_ch.repeat_period = '0;
    in_ch.slot_number   = '0;
    out_ch.ready        = 1'b0;
    cyc                 = 0;
    reqs_taken          = 0;
    results_owed        = 0;
    results_got         = 0;
    mismatches          = 0;
    hold_left           = 0;
    held_once           = 1'b0;
    on_bus              = '{default: '0};
    for (s = 0; s < SLOT_N; s++) drop_slot(s);

    // directed: empty table, bad deletes, fill to full, one-shot buildup
    queue_req(tts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 8'd255);
    queue_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 8'(SLOT_N));
    queue_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 8'd3);
    queue_req(tts_pkg::OP_ADD, 8'd0, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'd255, 16'hFFFF, 16'hFFFF, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'hA5, 16'd0, 16'd1, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'h5A, 16'd1, 16'd3, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'd1, 16'd2, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'd2, 16'd0, 16'd2, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'd3, 16'd1, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'd4, 16'd0, 16'hFFFF, 8'd0);
    queue_req(tts_pkg::OP_ADD, 8'd5, 16'd0, 16'd0, 8'd0);
    for (k = 0; k < 3; k++) queue_req(tts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 8'd7);
    queue_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 8'd7);
    queue_req(tts_pkg::OP_ADD, 8'h3C, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 8'd1);
    queue_pause();
    queue_req(tts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    queue_req(tts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0);

    rnd_count = 0;
    while (rnd_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          dly = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
          case ($urandom_range(0, 5))
            0, 1:    per = 16'd0;
            2:       per = 16'($urandom);
            default: per = 16'($urandom_range(1, 4));
          endcase
          queue_req(tts_pkg::OP_ADD, 8'($urandom), dly, per, 8'($urandom));
          rnd_count++;
        end
        3, 4: begin
          for (k = $urandom_range(1, 6); k > 0; k--) begin
            queue_req(tts_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                      8'($urandom));
            rnd_count++;
          end
        end
        5, 6: begin
          queue_req(tts_pkg::OP_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom));
          rnd_count++;
        end
        7: begin
          queue_req(tts_pkg::OP_DELETE, 8'($urandom), 16'($urandom), 16'($urandom),
                    ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, SLOT_N)));
          rnd_count++;
        end
        8: begin
          queue_req(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
          rnd_count++;
        end
        default: begin
          queue_pause();
          queue_req(tts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
          rnd_count++;
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() > 0 || in_ch.valid) @(posedge clk);
    while (results_owed != results_got) @(posedge clk);
    repeat (4 * SLOT_N + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tts_pkg.sv
sv/tts_in_if.sv
sv/tts_out_if.sv
sv/tts_ram.sv
sv/tts_ctrl.sv
sv/tts_out.sv
sv/tick_task_scheduler_table_unit.sv
sv/tts_chk.sv
tb/tb.sv
